// ===== rtl/fdp_pkg.sv =====
// Package for the frame deadline pacer: status codes, config indexes, widths.
// No dependencies.
`default_nettype none
package fdp_pkg;
    localparam int TW = 64;
    typedef logic [TW-1:0] word_t;

    typedef enum logic [2:0] {
        ST_DISABLED = 3'd0,
        ST_INVALID  = 3'd1,
        ST_NOCLOCK  = 3'd2,
        ST_READY    = 3'd3,
        ST_LATE     = 3'd4
    } status_t;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_RATE   = 1'b1;

    typedef struct packed {
        logic  frame_known;
        word_t frame_tag;
        logic  clock_present;
        word_t tick_rate_hz;
        logic  before_read_ok;
        word_t time_before;
        logic  wait_done_ok;
        logic  after_read_ok;
        word_t time_after;
    } req_t;

    typedef struct packed {
        logic [2:0] gate_status;
        logic       dup_frame;
        logic       arm_frame;
        logic       reanchored;
        logic       waited;
        logic       wait_met;
        word_t      observed_time;
        word_t      deadline_time;
        word_t      wait_span;
        word_t      late_ticks;
        logic [6:0] missed_count;
    } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/fdp_req_if.sv =====
// Valid/ready channel interface carrying a payload struct.
// Depends on fdp_pkg.
`default_nettype none
interface fdp_req_if import fdp_pkg::*; #(parameter type T = req_t);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/frame_deadline_pacer.sv =====
// Frame deadline pacer top level: sequencer around a shared 64-bit deadline step adder.
// Depends on fdp_pkg and fdp_req_if.
`default_nettype none
// One request in, one result out. An arm or re-anchor runs a restoring divider at
// one quotient bit per cycle. A late frame steps the deadline one period at a time
// (step, then compare) for up to MAX_CATCH_UP+2 periods and may then re-anchor.
// The input is not ready while a request is in work or while its result waits
// in the result register.
module frame_deadline_pacer import fdp_pkg::*; #(
    parameter int MAX_CATCH_UP = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_index,
    input  wire logic [15:0] cfg_data,
    fdp_req_if.sink    req,
    fdp_req_if.source  rsp
);
    localparam int CW = $clog2(MAX_CATCH_UP + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_WAITCHK, S_CLASS, S_DIV, S_DIVEND, S_STEP,
        S_STEPCHK, S_OUT
    } state_t;

    // anchor continuation: what to do after the initial step
    typedef enum logic [1:0] {A_FIRST, A_REAN, A_RECOVER} anc_t;
    // step continuation
    typedef enum logic [1:0] {P_ANCHOR, P_READY, P_LATE1, P_LATE} stp_t;

    state_t state_reg;
    anc_t   anc_reg;
    stp_t   stp_reg;
    logic   enable_reg;
    logic [15:0] rate_reg;
    logic   armed_reg, have_time_reg, have_tag_reg;
    word_t  anchor_rate_reg, pw_reg, nd_reg, last_time_reg, last_tag_reg;
    logic [15:0] pf_reg, acc_reg;
    req_t   in_reg;
    rsp_t   out_reg;
    logic   out_valid_reg;
    word_t  obs_reg, dq_reg;
    logic [16:0] drem_reg;
    logic [6:0] dcnt_reg;
    logic [CW-1:0] caught_reg;

    // shared step unit: next deadline candidate
    logic [16:0] carry_sum;
    logic        carry_hit;
    logic [16:0] carry_new;
    logic [64:0] inc_w, dl_sum;
    logic        step_ok;
    always_comb
    begin
        carry_sum = {1'b0, acc_reg} + {1'b0, pf_reg};
        carry_hit = carry_sum >= {1'b0, rate_reg};
        carry_new = carry_hit ? carry_sum - {1'b0, rate_reg} : carry_sum;
        inc_w     = {1'b0, pw_reg} + {64'd0, carry_hit};
        dl_sum    = {1'b0, nd_reg} + inc_w;
        step_ok   = (pw_reg != '0) && (rate_reg != '0) && (inc_w[63:0] != '0)
                    && !dl_sum[64];
    end

    // divider stage: one quotient bit
    logic [16:0] dshift;
    logic        dge;
    always_comb
    begin
        dshift = {drem_reg[15:0], dq_reg[63]};
        dge    = dshift >= {1'b0, rate_reg};
    end

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            anc_reg <= A_FIRST;
            stp_reg <= P_READY;
            enable_reg <= 1'b0;
            rate_reg <= 16'd120;
            armed_reg <= 1'b0;
            have_time_reg <= 1'b0;
            have_tag_reg <= 1'b0;
            anchor_rate_reg <= '0;
            pw_reg <= '0;
            pf_reg <= '0;
            acc_reg <= '0;
            nd_reg <= '0;
            last_time_reg <= '0;
            last_tag_reg <= '0;
            out_valid_reg <= 1'b0;
            caught_reg <= '0;
        end else begin
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
            // configuration writes
            if (cfg_we) begin
                if (cfg_index == CFG_ENABLE) begin
                    if (cfg_data[0] != enable_reg) begin
                        enable_reg <= cfg_data[0];
                        armed_reg <= 1'b0;
                        have_time_reg <= 1'b0;
                        have_tag_reg <= 1'b0;
                        anchor_rate_reg <= '0;
                        pw_reg <= '0;
                        pf_reg <= '0;
                        acc_reg <= '0;
                        nd_reg <= '0;
                        last_time_reg <= '0;
                        last_tag_reg <= '0;
                    end
                end else begin
                    rate_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready) begin
                        in_reg <= req.data;
                        out_reg <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                // gating, tag tracking and schedule decision
                S_CHECK:
                begin
                    state_reg <= S_OUT;
                    if (enable_reg) begin
                        if (!in_reg.frame_known) begin
                            have_tag_reg <= 1'b0;
                        end else begin
                            out_reg.dup_frame <= have_tag_reg
                                && (last_tag_reg == in_reg.frame_tag);
                            have_tag_reg <= 1'b1;
                            last_tag_reg <= in_reg.frame_tag;
                        end
                        if (rate_reg == '0) begin
                            out_reg.gate_status <= ST_INVALID;
                        end else if (!in_reg.clock_present
                            || in_reg.tick_rate_hz == '0 || !in_reg.before_read_ok) begin
                            out_reg.gate_status <= ST_NOCLOCK;
                            armed_reg <= 1'b0;
                        end else begin
                            out_reg.observed_time <= in_reg.time_before;
                            obs_reg <= in_reg.time_before;
                            if (in_reg.tick_rate_hz < {48'd0, rate_reg}) begin
                                out_reg.gate_status <= ST_INVALID;
                            end else if (!armed_reg) begin
                                anc_reg <= A_FIRST;
                                state_reg <= S_DIV;
                            end else if (in_reg.tick_rate_hz != anchor_rate_reg
                                || (have_time_reg
                                    && in_reg.time_before < last_time_reg)) begin
                                anc_reg <= A_REAN;
                                state_reg <= S_DIV;
                            end else begin
                                out_reg.deadline_time <= nd_reg;
                                state_reg <= S_WAITCHK;
                            end
                        end
                    end
                    // set up divider in case it is used
                    dq_reg <= in_reg.tick_rate_hz;
                    drem_reg <= '0;
                    dcnt_reg <= '0;
                end
                // wait handling when early
                S_WAITCHK:
                begin
                    state_reg <= S_CLASS;
                    if (obs_reg < nd_reg) begin
                        out_reg.waited <= 1'b1;
                        if (!in_reg.wait_done_ok) begin
                            armed_reg <= 1'b0;
                            out_reg.gate_status <= ST_NOCLOCK;
                            have_time_reg <= 1'b1;
                            last_time_reg <= in_reg.time_before;
                            state_reg <= S_OUT;
                        end else if (!in_reg.after_read_ok) begin
                            armed_reg <= 1'b0;
                            out_reg.gate_status <= ST_NOCLOCK;
                            state_reg <= S_OUT;
                        end else begin
                            obs_reg <= in_reg.time_after;
                            out_reg.observed_time <= in_reg.time_after;
                            if (in_reg.time_after >= in_reg.time_before)
                                out_reg.wait_span <= in_reg.time_after
                                    - in_reg.time_before;
                            if (in_reg.time_after >= nd_reg) begin
                                out_reg.wait_met <= 1'b1;
                            end else begin
                                armed_reg <= 1'b0;
                                out_reg.gate_status <= ST_NOCLOCK;
                                have_time_reg <= 1'b1;
                                last_time_reg <= in_reg.time_after;
                                state_reg <= S_OUT;
                            end
                        end
                    end
                end
                // ready or late
                S_CLASS:
                begin
                    have_time_reg <= 1'b1;
                    last_time_reg <= obs_reg;
                    caught_reg <= '0;
                    state_reg <= S_STEP;
                    if (obs_reg > nd_reg) begin
                        out_reg.gate_status <= ST_LATE;
                        out_reg.late_ticks <= obs_reg - nd_reg;
                        out_reg.missed_count <= 7'd1;
                        stp_reg <= P_LATE1;
                    end else begin
                        out_reg.gate_status <= ST_READY;
                        stp_reg <= P_READY;
                    end
                end
                // restoring division of tick rate by target rate
                S_DIV:
                begin
                    drem_reg <= dge ? dshift - {1'b0, rate_reg} : dshift;
                    dq_reg <= {dq_reg[62:0], dge};
                    dcnt_reg <= dcnt_reg + 7'd1;
                    if (dcnt_reg == 7'd63)
                        state_reg <= S_DIVEND;
                end
                S_DIVEND:
                begin
                    armed_reg <= 1'b1;
                    anchor_rate_reg <= in_reg.tick_rate_hz;
                    pw_reg <= dq_reg;
                    pf_reg <= drem_reg[15:0];
                    acc_reg <= '0;
                    nd_reg <= obs_reg;
                    stp_reg <= P_ANCHOR;
                    state_reg <= S_STEP;
                end
                // one period advance through the shared unit
                S_STEP:
                begin
                    if (step_ok) begin
                        nd_reg <= dl_sum[63:0];
                        acc_reg <= carry_new[15:0];
                    end
                    state_reg <= S_OUT;
                    unique case (stp_reg)
                        P_ANCHOR:
                        begin
                            if (!step_ok) armed_reg <= 1'b0;
                            // a failed first arm leaves the time history alone
                            if (step_ok || anc_reg != A_FIRST) begin
                                have_time_reg <= 1'b1;
                                last_time_reg <= obs_reg;
                            end
                            unique case (anc_reg)
                                A_FIRST:
                                begin
                                    if (step_ok) begin
                                        out_reg.arm_frame <= 1'b1;
                                        out_reg.gate_status <= ST_READY;
                                    end else begin
                                        out_reg.gate_status <= ST_NOCLOCK;
                                    end
                                end
                                A_REAN:
                                begin
                                    out_reg.reanchored <= 1'b1;
                                    out_reg.gate_status <= step_ok ? ST_READY
                                                                   : ST_NOCLOCK;
                                end
                                default:
                                begin
                                    out_reg.reanchored <= 1'b1;
                                end
                            endcase
                        end
                        P_READY:
                        begin
                            if (!step_ok) begin
                                anc_reg <= A_RECOVER;
                                dq_reg <= in_reg.tick_rate_hz;
                                drem_reg <= '0;
                                dcnt_reg <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                        default:
                        begin
                            stp_reg <= P_LATE;
                            state_reg <= S_STEPCHK;
                            if (!step_ok) begin
                                anc_reg <= A_RECOVER;
                                dq_reg <= in_reg.tick_rate_hz;
                                drem_reg <= '0;
                                dcnt_reg <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                    endcase
                end
                // catch-up decision after a successful step
                S_STEPCHK:
                begin
                    if (nd_reg < obs_reg) begin
                        if (caught_reg >= CW'(MAX_CATCH_UP)) begin
                            anc_reg <= A_RECOVER;
                            dq_reg <= in_reg.tick_rate_hz;
                            drem_reg <= '0;
                            dcnt_reg <= '0;
                            state_reg <= S_DIV;
                        end else begin
                            out_reg.missed_count <= out_reg.missed_count + 7'd1;
                            caught_reg <= caught_reg + CW'(1);
                            state_reg <= S_STEP;
                        end
                    end else if (nd_reg == obs_reg) begin
                        stp_reg <= P_READY;
                        state_reg <= S_STEP;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // a result is only loaded from the final state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output state");
    // no new transaction while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !req.ready)
        else $error("input ready while result pending");
    // catch-up never exceeds its cap
    a_catch_cap: assert property (@(posedge clk) disable iff (!rst_n)
        caught_reg <= CW'(MAX_CATCH_UP))
        else $error("catch-up count over cap");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/frame_deadline_pacer_checker.sv =====
// Scoreboard for the frame deadline pacer: watches the config port and both channels,
// predicts each result from its own copy of the pacing schedule and compares.
// Depends on fdp_pkg and fdp_req_if.
module frame_deadline_pacer_checker import fdp_pkg::*; #(
    parameter int MAX_CATCH_UP = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    fdp_req_if          req_mon,
    fdp_req_if          rsp_mon,
    output int          n_failed,
    output int          n_pending
);
    // configuration copy
    logic        enable_q;
    logic [15:0] goal_rate;

    // schedule copy
    logic        sched_armed;
    logic        seen_time;
    word_t       locked_rate;
    word_t       period_whole;
    logic [15:0] period_frac;
    logic [15:0] frac_carry;
    word_t       next_deadline;
    word_t       prev_time;
    logic        seen_tag;
    word_t       prev_tag;

    rsp_t        expected_rsps[$];

    assign n_pending = expected_rsps.size();

    function automatic void clear_schedule();
        sched_armed   = 1'b0;
        seen_time     = 1'b0;
        locked_rate   = '0;
        period_whole  = '0;
        period_frac   = '0;
        frac_carry    = '0;
        next_deadline = '0;
        prev_time     = '0;
        seen_tag      = 1'b0;
        prev_tag      = '0;
    endfunction

    // advance deadline one period; 0 when the period is empty or it would wrap
    function automatic bit advance_deadline();
        word_t       inc;
        logic [16:0] carry;
        if (period_whole == 0 || goal_rate == 0)
            return 1'b0;
        inc   = period_whole;
        carry = {1'b0, frac_carry} + {1'b0, period_frac};
        if (carry >= {1'b0, goal_rate}) begin
            inc   = inc + 64'd1;
            carry = carry - {1'b0, goal_rate};
        end
        if (inc == 0 || next_deadline > ~64'd0 - inc)
            return 1'b0;
        next_deadline = next_deadline + inc;
        frac_carry    = carry[15:0];
        return 1'b1;
    endfunction

    function automatic void anchor_schedule(word_t now, word_t rate);
        sched_armed = 1'b1;
        locked_rate = rate;
        if (goal_rate != 0) begin
            period_whole = rate / {48'd0, goal_rate};
            period_frac  = 16'(rate % {48'd0, goal_rate});
        end else begin
            period_whole = '0;
            period_frac  = '0;
        end
        frac_carry    = '0;
        next_deadline = now;
        if (!advance_deadline())
            sched_armed = 1'b0;
    endfunction

    function automatic rsp_t pace_frame(req_t q);
        rsp_t  r;
        word_t dl;
        word_t obs;
        int    caught;
        bit    ok;
        r = '0;
        r.gate_status = ST_DISABLED;
        if (!enable_q)
            return r;

        // duplicate tag tracking
        if (!q.frame_known) begin
            seen_tag = 1'b0;
        end else begin
            if (seen_tag && prev_tag == q.frame_tag)
                r.dup_frame = 1'b1;
            seen_tag = 1'b1;
            prev_tag = q.frame_tag;
        end

        if (goal_rate == 0) begin
            r.gate_status = ST_INVALID;
            return r;
        end
        if (!q.clock_present || q.tick_rate_hz == 0 || !q.before_read_ok) begin
            r.gate_status = ST_NOCLOCK;
            sched_armed   = 1'b0;
            return r;
        end
        r.observed_time = q.time_before;
        if (q.tick_rate_hz < {48'd0, goal_rate}) begin
            r.gate_status = ST_INVALID;
            return r;
        end

        // first arm
        if (!sched_armed) begin
            anchor_schedule(q.time_before, q.tick_rate_hz);
            if (!sched_armed) begin
                r.gate_status = ST_NOCLOCK;
                return r;
            end
            r.arm_frame   = 1'b1;
            r.gate_status = ST_READY;
            seen_time = 1'b1;
            prev_time = q.time_before;
            return r;
        end

        // rate change or time running backward
        if (q.tick_rate_hz != locked_rate || (seen_time && q.time_before < prev_time)) begin
            anchor_schedule(q.time_before, q.tick_rate_hz);
            r.reanchored  = 1'b1;
            r.gate_status = sched_armed ? ST_READY : ST_NOCLOCK;
            seen_time = 1'b1;
            prev_time = q.time_before;
            return r;
        end

        dl  = next_deadline;
        obs = q.time_before;
        r.deadline_time = dl;
        if (obs < dl) begin
            r.waited = 1'b1;
            if (!q.wait_done_ok) begin
                sched_armed   = 1'b0;
                r.gate_status = ST_NOCLOCK;
                seen_time = 1'b1;
                prev_time = q.time_before;
                return r;
            end
            if (!q.after_read_ok) begin
                sched_armed   = 1'b0;
                r.gate_status = ST_NOCLOCK;
                return r;
            end
            obs = q.time_after;
            r.observed_time = obs;
            if (obs >= q.time_before)
                r.wait_span = obs - q.time_before;
            r.wait_met = (obs >= dl);
            if (!r.wait_met) begin
                sched_armed   = 1'b0;
                r.gate_status = ST_NOCLOCK;
                seen_time = 1'b1;
                prev_time = obs;
                return r;
            end
        end

        if (obs > dl) begin
            // late: catch up a bounded number of periods
            r.gate_status  = ST_LATE;
            r.late_ticks   = obs - dl;
            r.missed_count = 7'd1;
            caught = 0;
            ok = advance_deadline();
            while (ok && next_deadline < obs && caught < MAX_CATCH_UP) begin
                r.missed_count = r.missed_count + 7'd1;
                caught++;
                ok = advance_deadline();
            end
            if (ok && next_deadline == obs)
                ok = advance_deadline();
            if (!ok || (next_deadline < obs && caught >= MAX_CATCH_UP)) begin
                anchor_schedule(obs, q.tick_rate_hz);
                r.reanchored = 1'b1;
            end
        end else begin
            r.gate_status = ST_READY;
            if (!advance_deadline()) begin
                anchor_schedule(obs, q.tick_rate_hz);
                r.reanchored = 1'b1;
            end
        end
        r.observed_time = obs;
        seen_time = 1'b1;
        prev_time = obs;
        return r;
    endfunction

    // config writes, request predictions, result comparison
    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        rsp_t got;
        if (!rst_n) begin
            enable_q  = 1'b0;
            goal_rate = 16'd120;
            n_failed  <= 0;
            clear_schedule();
            expected_rsps.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_ENABLE) begin
                    if (cfg_data[0] != enable_q) begin
                        enable_q = cfg_data[0];
                        clear_schedule();
                    end
                end else begin
                    goal_rate = cfg_data;
                end
            end
            if (req_mon.valid && req_mon.ready)
                expected_rsps.push_back(pace_frame(req_mon.data));
            if (rsp_mon.valid && rsp_mon.ready) begin
                got = rsp_mon.data;
                if (expected_rsps.size() == 0) begin
                    $error("result transaction with nothing expected");
                    n_failed <= n_failed + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (got != want) begin
                        n_failed <= n_failed + 1;
                        if (got.gate_status != want.gate_status)
                            $error("gate_status exp %0d got %0d",
                                   want.gate_status, got.gate_status);
                        if (got.dup_frame != want.dup_frame)
                            $error("dup_frame exp %0d got %0d", want.dup_frame, got.dup_frame);
                        if (got.arm_frame != want.arm_frame)
                            $error("arm_frame exp %0d got %0d",
                                   want.arm_frame, got.arm_frame);
                        if (got.reanchored != want.reanchored)
                            $error("reanchored exp %0d got %0d",
                                   want.reanchored, got.reanchored);
                        if (got.waited != want.waited)
                            $error("waited exp %0d got %0d", want.waited, got.waited);
                        if (got.wait_met != want.wait_met)
                            $error("wait_met exp %0d got %0d",
                                   want.wait_met, got.wait_met);
                        if (got.observed_time != want.observed_time)
                            $error("observed_time exp %h got %h",
                                   want.observed_time, got.observed_time);
                        if (got.deadline_time != want.deadline_time)
                            $error("deadline_time exp %h got %h",
                                   want.deadline_time, got.deadline_time);
                        if (got.wait_span != want.wait_span)
                            $error("wait_span exp %h got %h", want.wait_span, got.wait_span);
                        if (got.late_ticks != want.late_ticks)
                            $error("late_ticks exp %h got %h", want.late_ticks, got.late_ticks);
                        if (got.missed_count != want.missed_count)
                            $error("missed_count exp %0d got %0d",
                                   want.missed_count, got.missed_count);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/frame_deadline_pacer_test.sv =====
// Top of the frame deadline pacer testbench: clock, reset, config phases, request
// stimulus and result backpressure; verdict from the checker's failure count.
// Depends on fdp_pkg, fdp_req_if, frame_deadline_pacer and frame_deadline_pacer_checker.
module frame_deadline_pacer_test;
    import fdp_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     SETTLE      = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          n_failed;
    int          n_pending;
    longint      cycles = 0;

    fdp_req_if #(.T(req_t)) req_ch ();
    fdp_req_if #(.T(rsp_t)) rsp_ch ();

    frame_deadline_pacer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    frame_deadline_pacer_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_mon   (req_ch),
        .rsp_mon   (rsp_ch),
        .n_failed  (n_failed),
        .n_pending (n_pending)
    );

    // generator view of the stream
    logic [15:0] gen_target;
    word_t       gen_time;
    word_t       gen_rate;
    word_t       gen_tag;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("frame_deadline_pacer test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 65)
            return 0;
        if (k < 94)
            return $urandom_range(1, 4);
        return $urandom_range(20, 70);
    endfunction

    // result backpressure: bursts without stalls, otherwise random stalls
    int  stall_left;
    bit  no_stall_run;
    int  run_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            no_stall_run <= 1'b0;
            run_left     <= 0;
        end
        else
        begin
            if (run_left == 0)
            begin
                no_stall_run <= ($urandom_range(0, 3) == 0);
                run_left     <= $urandom_range(50, 400);
            end
            else
            begin
                run_left <= run_left - 1;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (!no_stall_run && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= pick_gap();
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == CFG_RATE)
            gen_target = value;
    endtask

    // one request transaction; valid stays high across back-to-back transactions
    task automatic send_frame(req_t q);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // let the checker queue the last transaction before waiting for all results to drain
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic req_t mk(logic known, word_t tag, logic clk_ok, word_t rate,
                                logic bok, word_t t0, logic wok, logic aok, word_t t1);
        req_t q;
        q.frame_known    = known;
        q.frame_tag      = tag;
        q.clock_present  = clk_ok;
        q.tick_rate_hz   = rate;
        q.before_read_ok = bok;
        q.time_before    = t0;
        q.wait_done_ok   = wok;
        q.after_read_ok  = aok;
        q.time_after     = t1;
        return q;
    endfunction

    function automatic word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // random value in a 32-bit range, widened to a word
    function automatic word_t urange(int unsigned lo, int unsigned hi);
        return {32'd0, $urandom_range(lo, hi)};
    endfunction

    // well-formed pacing traffic with occasional faults, plus some noise
    function automatic req_t gen_frame();
        req_t  q;
        word_t per;
        int    k;
        if ($urandom_range(0, 99) < 5)
            return mk($urandom_range(0, 1) != 0, rand_word(), $urandom_range(0, 1) != 0,
                      rand_word(), $urandom_range(0, 1) != 0, rand_word(),
                      $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0, rand_word());
        k = $urandom_range(0, 99);
        if (k < 4)
            gen_rate = urange(1000, 2000000);
        else if (k < 6)
            gen_rate = rand_word();
        else if (k < 7)
            gen_rate = urange(0, 200);
        per = (gen_target == 0) ? 64'd1 : gen_rate / {48'd0, gen_target};
        if (per == 0)
            per = 1;
        k = $urandom_range(0, 99);
        if (k < 40)
            gen_time = gen_time + per - per / 64'd4 + urange(0, 32'(per / 64'd2));
        else if (k < 60)
            gen_time = gen_time + urange(0, 32'(per));
        else if (k < 75)
            gen_time = gen_time + per * urange(2, 10);
        else if (k < 80)
            gen_time = gen_time + per * urange(66, 200);
        else if (k < 85)
            gen_time = gen_time - urange(1, 32'(per * 64'd3));
        else if (k < 87)
            gen_time = ~64'd0 - urange(0, 32'(per * 64'd4));
        else if (k < 88)
            gen_time = rand_word();
        k = $urandom_range(0, 99);
        if (k < 8)
            gen_tag = gen_tag;
        else if (k < 13)
            gen_tag = rand_word();
        else
            gen_tag = gen_tag + 64'd1;
        q = mk($urandom_range(0, 19) != 0, gen_tag, $urandom_range(0, 49) != 0, gen_rate,
               $urandom_range(0, 49) != 0, gen_time, $urandom_range(0, 29) != 0,
               $urandom_range(0, 29) != 0,
               gen_time + urange(0, 32'(per * 64'd2 + 64'd1)));
        if ($urandom_range(0, 9) == 0)
            q.time_after = gen_time - urange(0, 32'(per));
        return q;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_frame(gen_frame());
        drain();
    endtask

    localparam word_t TOP = ~64'd0;

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ENABLE;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        gen_target   = 16'd120;
        gen_time     = 64'd100000;
        gen_rate     = 64'd1200000;
        gen_tag      = 64'd1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled gate returns disabled
        send_frame(mk(1, 5, 1, 1200, 1, 1000, 1, 1, 1000));
        drain();

        // directed: target 120, rate 1200 gives a 10 tick period
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_RATE, 16'd120);
        send_frame(mk(1, 7, 1, 1200, 1, 1000, 1, 1, 0));             // first arm
        send_frame(mk(1, 7, 1, 1200, 1, 1005, 1, 1, 1010));          // dup, waits, on time
        send_frame(mk(0, 0, 1, 1200, 1, 1030, 1, 1, 0));             // late, unknown frame
        send_frame(mk(1, TOP, 1, 1200, 1, 3000, 1, 1, 0));           // late beyond catch-up cap
        send_frame(mk(1, 0, 1, 1200, 1, 500, 1, 1, 0));              // time backward
        send_frame(mk(1, 1, 1, 1201, 1, 600, 1, 1, 0));              // rate change
        send_frame(mk(1, 2, 1, 1201, 1, 605, 0, 1, 0));              // wait failed
        send_frame(mk(1, 3, 1, 1200, 1, 700, 1, 1, 0));              // rearm
        send_frame(mk(1, 4, 1, 1200, 1, 702, 1, 0, 0));              // after-read failed
        send_frame(mk(1, 5, 1, 1200, 1, 710, 1, 1, 0));              // rearm
        send_frame(mk(1, 6, 1, 1200, 1, 712, 1, 1, 715));            // wait fell short
        send_frame(mk(1, 7, 1, 1200, 1, 720, 1, 1, 0));
        send_frame(mk(1, 8, 1, 1200, 1, 730, 1, 1, 0));              // exactly on deadline
        send_frame(mk(1, 9, 0, 1200, 1, 740, 1, 1, 0));              // clock missing
        send_frame(mk(1, 10, 1, 0, 1, 740, 1, 1, 0));                // zero tick rate
        send_frame(mk(1, 11, 1, 1200, 0, 740, 1, 1, 0));             // before-read failed
        send_frame(mk(1, 12, 1, 50, 1, 740, 1, 1, 0));               // rate below target
        send_frame(mk(1, 13, 1, 1200, 1, TOP - 5, 1, 1, 0));         // overflow on arm
        send_frame(mk(1, 14, 1, 1200, 1, TOP - 25, 1, 1, 0));
        send_frame(mk(1, 15, 1, 1200, 1, TOP - 12, 1, 1, 0));        // late near the top of the time range
        send_frame(mk(1, 16, 1, TOP, 1, TOP, 1, 1, TOP));            // field maxima
        drain();

        // random phases across settings
        random_phase(130);
        write_reg(CFG_RATE, 16'd1);                                  // rate change while armed
        random_phase(120);
        write_reg(CFG_RATE, 16'hFFFF);
        gen_rate = 64'd5000000;
        random_phase(120);
        write_reg(CFG_RATE, 16'd0);
        random_phase(25);
        write_reg(CFG_ENABLE, 16'd1);                                // same value keeps state
        write_reg(CFG_RATE, 16'd60);
        random_phase(120);
        write_reg(CFG_ENABLE, 16'd0);
        random_phase(25);
        write_reg(CFG_ENABLE, 16'd1);
        repeat (6)
        begin
            write_reg(CFG_RATE, 16'($urandom_range(1, 2000)));
            gen_rate = urange(2000, 3000000);
            random_phase(115);
        end

        if (n_failed == 0)
            $display("frame_deadline_pacer test passed");
        else
            $display("frame_deadline_pacer test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/fdp_pkg.sv
rtl/fdp_req_if.sv
rtl/frame_deadline_pacer.sv
tb/sv/frame_deadline_pacer_checker.sv
tb/sv/frame_deadline_pacer_test.sv
